[design/hrrn_pkg.sv]
// Package of the highest-response-ratio-next scheduler.
// Holds sizes, field widths and the controller state type; it depends on nothing.
`default_nettype none
package hrrn_pkg;

  localparam int MAX_JOBS   = 16;
  localparam int TIME_WIDTH = 16;
  localparam int JOB_W      = $clog2(MAX_JOBS);
  localparam int CNT_W      = $clog2(MAX_JOBS + 1);
  localparam int CLK_W      = 21;
  localparam int PROD_W     = CLK_W + TIME_WIDTH;
  localparam int ENTRY_W    = 2 * TIME_WIDTH;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 72;
  localparam int IDX_OUT_W  = 4;

  typedef enum logic [2:0] {
    S_LOAD,
    S_START,
    S_LD,
    S_MUL,
    S_FIN,
    S_DEC,
    S_EMIT
  } state_t;

endpackage
`default_nettype wire

[design/hrrn_ram.sv]
// Generic RAM of the scheduler: one write port and one read port with registered data.
// Stands alone; it depends on no package.
`default_nettype none
module hrrn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[design/hrrn_process_scheduler.sv]
// Top level of the non-preemptive highest-response-ratio-next scheduler.
// Depends on hrrn_pkg and hrrn_ram, which holds the arrival and burst of each job.
//
//   channel  direction  transfer holds
//   in_      slave      one job: arrival, burst; tlast starts scheduling
//   out_     master     one scheduled job: index, completion, turnaround, wait
//
// Loading accepts one job per cycle. Each scheduling decision scans the N stored
// jobs through the single read port of the job memory, visiting each job in the
// states S_LD and S_MUL, and one extra scan runs each time no job is ready and
// time jumps to the next arrival.
// Reset clears the job count, the done flags and the output valid flag.
// A stalled output holds its result; the next scan runs meanwhile and waits
// only when its own result is ready.
`default_nettype none
module hrrn_process_scheduler (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // in_tdata fields from bit 0: arrival[15:0], burst[31:16].
  input  wire logic [hrrn_pkg::IN_DATA_W-1:0]   in_tdata,
  input  wire logic                             in_tlast,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // out_tdata fields from bit 0: job_index[3:0], completion[24:4],
  // turnaround[45:25], waiting[66:46], zero fill[71:67].
  output logic      [hrrn_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                                  out_tlast
);

  localparam int TW  = hrrn_pkg::TIME_WIDTH;
  localparam int JW  = hrrn_pkg::JOB_W;
  localparam int CW  = hrrn_pkg::CNT_W;
  localparam int KW  = hrrn_pkg::CLK_W;
  localparam int PW  = hrrn_pkg::PROD_W;

  hrrn_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]           count_r;
  logic [CW-1:0]           fin_r;
  logic [hrrn_pkg::MAX_JOBS-1:0] done_r;
  logic [KW-1:0]           clock_r;
  logic [JW-1:0]           rd_idx_r;

  logic [TW-1:0]           cand_a_r, cand_b_r;
  logic [KW-1:0]           cand_num_r;
  logic [JW-1:0]           cand_idx_r;
  logic                    cand_elig_r;
  logic [PW-1:0]           prod1_r, prod2_r;
  logic                    prod_vld_r;

  logic [TW-1:0]           best_a_r, best_b_r;
  logic [KW-1:0]           best_num_r;
  logic [JW-1:0]           best_idx_r;
  logic                    best_vld_r;
  logic [TW-1:0]           min_a_r;
  logic                    min_vld_r;

  logic                    out_vld_r;
  logic [hrrn_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                    out_last_r;

  logic                    in_acc;
  logic                    ram_we;
  logic [JW-1:0]           ram_raddr;
  logic [hrrn_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [TW-1:0]           in_arr, in_bur;
  logic [TW-1:0]           rd_a, rd_b;
  logic [JW-1:0]           last_idx;
  logic                    scan_last;
  logic                    slot_free;
  logic                    do_cmp;
  logic                    cand_wins;
  logic [KW-1:0]           res_wait, res_compl, res_turn;
  logic                    set_done;

  assign in_arr    = in_tdata[TW-1:0];
  assign in_bur    = (in_tdata[2*TW-1:TW] == '0) ? TW'(1) : in_tdata[2*TW-1:TW];
  assign ram_wdata = {in_bur, in_arr};
  assign rd_a      = ram_rdata[TW-1:0];
  assign rd_b      = ram_rdata[2*TW-1:TW];
  assign last_idx  = JW'(count_r - CW'(1));
  assign scan_last = (rd_idx_r == last_idx);
  assign slot_free = !out_vld_r || out_tready;
  assign cand_wins = cand_elig_r && (!best_vld_r || (prod1_r > prod2_r));
  assign res_wait  = clock_r - KW'(best_a_r);
  assign res_compl = clock_r + KW'(best_b_r);
  assign res_turn  = res_wait + KW'(best_b_r);
  assign set_done  = ((fin_r + CW'(1)) == count_r);

  hrrn_ram #(
    .WIDTH(hrrn_pkg::ENTRY_W),
    .DEPTH(hrrn_pkg::MAX_JOBS)
  ) u_job_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count_r[JW-1:0]),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hrrn_pkg::S_LOAD: begin
        if (in_acc && in_tlast) begin
          state_nxt = hrrn_pkg::S_START;
        end
      end
      hrrn_pkg::S_START: state_nxt = hrrn_pkg::S_LD;
      hrrn_pkg::S_LD:    state_nxt = hrrn_pkg::S_MUL;
      hrrn_pkg::S_MUL: begin
        state_nxt = scan_last ? hrrn_pkg::S_FIN : hrrn_pkg::S_LD;
      end
      hrrn_pkg::S_FIN:   state_nxt = hrrn_pkg::S_DEC;
      hrrn_pkg::S_DEC: begin
        state_nxt = best_vld_r ? hrrn_pkg::S_EMIT : hrrn_pkg::S_START;
      end
      hrrn_pkg::S_EMIT: begin
        if (slot_free) begin
          state_nxt = set_done ? hrrn_pkg::S_LOAD : hrrn_pkg::S_START;
        end
      end
      default: state_nxt = hrrn_pkg::S_LOAD;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    ram_raddr = rd_idx_r;
    do_cmp    = 1'b0;
    case (state_r)
      hrrn_pkg::S_LOAD:  in_tready = 1'b1;
      hrrn_pkg::S_START: ram_raddr = '0;
      hrrn_pkg::S_LD:    do_cmp    = prod_vld_r;
      hrrn_pkg::S_MUL:   ram_raddr = rd_idx_r + JW'(1);
      hrrn_pkg::S_FIN:   do_cmp    = prod_vld_r;
      default:           ram_raddr = rd_idx_r;
    endcase
  end

  assign in_acc = in_tvalid && in_tready;
  assign ram_we = in_acc && (count_r < CW'(hrrn_pkg::MAX_JOBS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= hrrn_pkg::S_LOAD;
      count_r    <= '0;
      fin_r      <= '0;
      done_r     <= '0;
      clock_r    <= '0;
      out_vld_r  <= 1'b0;
      prod_vld_r <= 1'b0;
      best_vld_r <= 1'b0;
      min_vld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_tready && (state_r != hrrn_pkg::S_EMIT)) begin
        out_vld_r <= 1'b0;
      end
      if (ram_we) begin
        count_r <= count_r + CW'(1);
      end
      case (state_r)
        hrrn_pkg::S_START: begin
          prod_vld_r <= 1'b0;
          best_vld_r <= 1'b0;
          min_vld_r  <= 1'b0;
        end
        hrrn_pkg::S_LD: begin
          if (!done_r[rd_idx_r] && (!min_vld_r || (rd_a < min_a_r))) begin
            min_vld_r <= 1'b1;
          end
          if (do_cmp && cand_wins) begin
            best_vld_r <= 1'b1;
          end
        end
        hrrn_pkg::S_MUL: prod_vld_r <= 1'b1;
        hrrn_pkg::S_FIN: begin
          if (do_cmp && cand_wins) begin
            best_vld_r <= 1'b1;
          end
        end
        hrrn_pkg::S_DEC: begin
          if (!best_vld_r) begin
            clock_r <= KW'(min_a_r);
          end
        end
        hrrn_pkg::S_EMIT: begin
          if (slot_free) begin
            out_vld_r <= 1'b1;
            if (set_done) begin
              count_r <= '0;
              fin_r   <= '0;
              done_r  <= '0;
              clock_r <= '0;
            end else begin
              fin_r            <= fin_r + CW'(1);
              done_r[best_idx_r] <= 1'b1;
              clock_r          <= res_compl;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      hrrn_pkg::S_START: rd_idx_r <= '0;
      hrrn_pkg::S_LD: begin
        cand_a_r    <= rd_a;
        cand_b_r    <= rd_b;
        cand_num_r  <= clock_r - KW'(rd_a) + KW'(rd_b);
        cand_idx_r  <= rd_idx_r;
        cand_elig_r <= !done_r[rd_idx_r] && (KW'(rd_a) <= clock_r);
        if (!done_r[rd_idx_r] && (!min_vld_r || (rd_a < min_a_r))) begin
          min_a_r <= rd_a;
        end
      end
      hrrn_pkg::S_MUL: begin
        prod1_r  <= PW'(cand_num_r) * PW'(best_b_r);
        prod2_r  <= PW'(best_num_r) * PW'(cand_b_r);
        rd_idx_r <= rd_idx_r + JW'(1);
      end
      hrrn_pkg::S_EMIT: begin
        if (slot_free) begin
          out_data_r <= {5'd0, res_wait, res_turn, res_compl,
                         hrrn_pkg::IDX_OUT_W'(best_idx_r)};
          out_last_r <= set_done;
        end
      end
      default: begin
      end
    endcase
    if (do_cmp && cand_wins) begin
      best_a_r   <= cand_a_r;
      best_b_r   <= cand_b_r;
      best_num_r <= cand_num_r;
      best_idx_r <= cand_idx_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

[tb/sv/hrrn_sched_checker.sv]
// Checker for the highest-response-ratio-next scheduler: it watches both stream channels,
// schedules every loaded job set itself and compares each result transfer with its own schedule.
// Depends on hrrn_pkg for the sizes and the bus widths.
module hrrn_sched_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [hrrn_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tlast,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [hrrn_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            out_tlast,
  output int                              fail_cnt,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TW = hrrn_pkg::TIME_WIDTH;

  typedef struct {
    logic [3:0]  job_index;
    logic [20:0] completion;
    logic [20:0] turnaround;
    logic [20:0] waiting;
    logic        final_res;
  } job_run_t;

  logic [TW-1:0] arrival_q[hrrn_pkg::MAX_JOBS];
  logic [TW-1:0] burst_q[hrrn_pkg::MAX_JOBS];
  bit            finished_q[hrrn_pkg::MAX_JOBS];
  int            n_jobs;
  job_run_t      expected_runs[$];

  initial begin
    fail_cnt = 0;
    pending  = 0;
    n_jobs   = 0;
    foreach (finished_q[i]) finished_q[i] = 1'b0;
  end

  // Exact compare of (wait_a + burst_a) / burst_a against the same ratio of job b.
  function automatic bit ratio_beats(int a, int b, logic [31:0] now);
    logic [63:0] wait_a;
    logic [63:0] wait_b;
    logic [63:0] lhs;
    logic [63:0] rhs;
    wait_a = 64'(now) - 64'(arrival_q[a]);
    wait_b = 64'(now) - 64'(arrival_q[b]);
    lhs = (wait_a + 64'(burst_q[a])) * 64'(burst_q[b]);
    rhs = (wait_b + 64'(burst_q[b])) * 64'(burst_q[a]);
    return lhs > rhs;
  endfunction

  function automatic void schedule_set();
    logic [31:0] now;
    logic [31:0] next_arrival;
    logic [31:0] wait_ticks;
    int          sel;
    int          finished;
    bit          any;
    job_run_t    run;
    now = 0;
    finished = 0;
    while (finished < n_jobs) begin
      sel = -1;
      for (int i = 0; i < n_jobs; i++) begin
        if (!finished_q[i] && 32'(arrival_q[i]) <= now) begin
          if (sel < 0 || ratio_beats(i, sel, now)) sel = i;
        end
      end
      if (sel < 0) begin
        any = 1'b0;
        next_arrival = 0;
        for (int i = 0; i < n_jobs; i++) begin
          if (!finished_q[i] && (!any || 32'(arrival_q[i]) < next_arrival)) begin
            next_arrival = 32'(arrival_q[i]);
            any = 1'b1;
          end
        end
        now = next_arrival;
      end else begin
        wait_ticks = now - 32'(arrival_q[sel]);
        now = now + 32'(burst_q[sel]);
        finished_q[sel] = 1'b1;
        run.job_index  = 4'(sel);
        run.completion = 21'(now);
        run.turnaround = 21'(now - 32'(arrival_q[sel]));
        run.waiting    = 21'(wait_ticks);
        run.final_res  = (finished == n_jobs - 1);
        expected_runs.push_back(run);
        finished++;
      end
    end
    foreach (finished_q[i]) finished_q[i] = 1'b0;
    n_jobs = 0;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    job_run_t    exp_run;
    logic [TW-1:0] arr;
    logic [TW-1:0] bur;
    if (rst_n) begin
      // A result transfer at the same edge as a closing job belongs to the set before it.
      if (out_tvalid && out_tready) begin
        if (expected_runs.size() == 0) begin
          $error("result transfer with no scheduled job waiting: tdata %h", out_tdata);
          fail_cnt++;
        end else begin
          exp_run = expected_runs.pop_front();
          check_field("job_index", 32'(exp_run.job_index), 32'(out_tdata[3:0]));
          check_field("completion", 32'(exp_run.completion), 32'(out_tdata[24:4]));
          check_field("turnaround", 32'(exp_run.turnaround), 32'(out_tdata[45:25]));
          check_field("waiting", 32'(exp_run.waiting), 32'(out_tdata[66:46]));
          check_field("final_res", 32'(exp_run.final_res), 32'(out_tlast));
        end
      end
      if (in_tvalid && in_tready) begin
        arr = in_tdata[TW-1:0];
        bur = in_tdata[16 +: TW];
        if (bur == 0) bur = 1;
        if (n_jobs < hrrn_pkg::MAX_JOBS) begin
          arrival_q[n_jobs]  = arr;
          burst_q[n_jobs]    = bur;
          finished_q[n_jobs] = 1'b0;
          n_jobs++;
        end
        if (in_tlast) schedule_set();
      end
      pending = expected_runs.size();
    end
  end

endmodule

[tb/sv/tb_top.sv]
// Top of the scheduler testbench: clock, reset, job stimulus, output back-pressure and verdict.
// Depends on hrrn_pkg, the hrrn_process_scheduler block and the hrrn_sched_checker module.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 410;
  localparam int IDLE_LIMIT   = 5000;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 300;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  wire                             in_tready;
  logic [hrrn_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                            in_tlast;
  wire                             out_tvalid;
  logic                            out_tready;
  wire  [hrrn_pkg::OUT_DATA_W-1:0] out_tdata;
  wire                             out_tlast;
  int                              fail_cnt;
  int                              pending;

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;

  hrrn_process_scheduler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  hrrn_sched_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_cnt   (fail_cnt),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    int hold_left;
    hold_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  task automatic push_job(input logic [15:0] arr, input logic [15:0] bur, input logic lst);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {bur, arr};
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic play_set(input int n_items);
    int          style;
    int          pick;
    logic [15:0] base;
    logic [15:0] arr;
    logic [15:0] bur;
    style = $urandom_range(99);
    base  = ($urandom_range(3) == 0) ? 16'(0) : 16'($urandom);
    for (int i = 0; i < n_items; i++) begin
      if (style < 60) begin
        arr = base + 16'($urandom_range(0, 24));
        bur = 16'($urandom_range(0, 12));
      end else if (style < 85) begin
        arr = 16'($urandom);
        bur = ($urandom_range(15) == 0) ? 16'(0) : 16'($urandom);
      end else begin
        pick = $urandom_range(3);
        arr  = (pick[0]) ? 16'hFFFF : 16'h0000;
        pick = $urandom_range(3);
        case (pick)
          0: bur = 16'h0000;
          1: bur = 16'h0001;
          2: bur = 16'hFFFF;
          default: bur = 16'($urandom);
        endcase
      end
      push_job(arr, bur, i == n_items - 1);
    end
  endtask

  initial begin
    int sent;
    int sets;
    int n_items;
    int size_pick;
    int phase;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    hold_req  = 1'b0;
    send_idle_pct = 28;
    recv_idle_pct = 71;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push_job(16'd0, 16'd1, 1'b1);
    push_job(16'hFFFF, 16'hFFFF, 1'b1);
    push_job(16'd5, 16'd0, 1'b0);
    push_job(16'd0, 16'd0, 1'b1);
    push_job(16'd0, 16'd10, 1'b0);
    push_job(16'd0, 16'd10, 1'b1);
    push_job(16'd0, 16'd8, 1'b0);
    push_job(16'd1, 16'd2, 1'b0);
    push_job(16'd2, 16'd1, 1'b1);
    push_job(16'd100, 16'd3, 1'b0);
    push_job(16'd50, 16'd4, 1'b0);
    push_job(16'd300, 16'd2, 1'b1);
    push_job(16'd0, 16'hFFFF, 1'b0);
    push_job(16'd0, 16'hFFFF, 1'b0);
    push_job(16'hFFFF, 16'hFFFF, 1'b1);

    sent = 0;
    sets = 0;
    while (sent < RANDOM_ITEMS) begin
      phase = sent * 3 / RANDOM_ITEMS;
      case (phase)
        0: begin
          send_idle_pct = 28;
          recv_idle_pct = 71;
        end
        1: begin
          send_idle_pct = 71;
          recv_idle_pct = 28;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      size_pick = $urandom_range(99);
      if (size_pick < 80) n_items = $urandom_range(1, 6);
      else if (size_pick < 92) n_items = $urandom_range(7, 16);
      else n_items = $urandom_range(17, 20);
      // Stall the result side for a long stretch while a full set and the next one are offered.
      if (sets % 25 == 7) begin
        hold_req = 1'b1;
        n_items = hrrn_pkg::MAX_JOBS;
      end
      play_set(n_items);
      sent += n_items;
      sets++;
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
